// File: rtl/core/catu_pkg.sv
// shared types, constants and arctangent table for the atan2 unwrap block
package catu_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TABLE_DEPTH       = 24;
    localparam int STEP_W            = $clog2(TABLE_DEPTH);
    localparam int VEC_W             = 36;   // prescaled vector plus cordic growth
    localparam int ANG_W             = 40;   // unwrap arithmetic width
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;
    localparam int REG_HALF_TURN     = 0;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ARC_TABLE [TABLE_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SUM,
        ST_FIX_HI,
        ST_FIX_LO
    } catu_state_t;

    typedef struct packed {
        logic              load;
        logic              rotate;
        logic              sum;
        logic              fix_hi;
        logic              commit;
        logic [STEP_W-1:0] step;
    } catu_cmd_t;

    typedef struct packed {
        logic out_free;
    } catu_status_t;

endpackage

// File: rtl/core/catu_ctrl.sv
// controller: sequences load, cordic steps, unwrap fixes and result commit
module catu_ctrl #(
    parameter int CORDIC_STEPS = catu_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  catu_pkg::catu_status_t status,
    output catu_pkg::catu_cmd_t    cmd
);

    localparam int NUM_STEPS = (CORDIC_STEPS > catu_pkg::TABLE_DEPTH) ?
                               catu_pkg::TABLE_DEPTH : CORDIC_STEPS;
    localparam logic [catu_pkg::STEP_W-1:0] LAST_STEP = catu_pkg::STEP_W'(NUM_STEPS - 1);

    catu_pkg::catu_state_t state_reg, state_next;
    logic [catu_pkg::STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= catu_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            catu_pkg::ST_IDLE: begin
                step_next = '0;
                if (s_tvalid) begin
                    state_next = catu_pkg::ST_ROTATE;
                end
            end
            catu_pkg::ST_ROTATE: begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = catu_pkg::ST_SUM;
                end
            end
            catu_pkg::ST_SUM: begin
                state_next = catu_pkg::ST_FIX_HI;
            end
            catu_pkg::ST_FIX_HI: begin
                state_next = catu_pkg::ST_FIX_LO;
            end
            catu_pkg::ST_FIX_LO: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    state_next = catu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = catu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            catu_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            catu_pkg::ST_ROTATE: begin
                cmd.rotate = 1'b1;
            end
            catu_pkg::ST_SUM: begin
                cmd.sum = 1'b1;
            end
            catu_pkg::ST_FIX_HI: begin
                cmd.fix_hi = 1'b1;
            end
            catu_pkg::ST_FIX_LO: begin
                cmd.commit = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/catu_datapath.sv
// datapath: cordic vectoring registers, unwrap arithmetic and output register
module catu_datapath #(
    parameter int FRACTION_BITS = catu_pkg::FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  catu_pkg::catu_cmd_t    cmd,
    output catu_pkg::catu_status_t status,
    input  logic                   half_turn_period,
    input  logic signed [15:0]     y_component,
    input  logic signed [15:0]     x_component,
    input  logic                   restart,
    input  logic signed [31:0]     seed_angle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            unwrapped_angle
);

    localparam int VW = catu_pkg::VEC_W;
    localparam int AW = catu_pkg::ANG_W;
    localparam logic [AW-1:0] MASK_FULL = (AW'(1) << FRACTION_BITS) - AW'(1);
    localparam logic [AW-1:0] MASK_HALF = (AW'(1) << (FRACTION_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] EIGHTH = AW'(1) << (FRACTION_BITS - 3);
    localparam logic signed [32:0] ROUND_HALF = 33'd1 << (31 - FRACTION_BITS);

    logic signed [VW-1:0] x_reg, y_reg;
    logic [31:0]          z_reg;
    logic                 zero_reg;
    logic signed [31:0]   ref_reg;
    logic signed [AW-1:0] temp_reg, hi_reg, lo_reg;
    logic signed [31:0]   reference_reg;
    logic [31:0]          out_data_reg;
    logic                 out_valid_reg;

    logic signed [VW-1:0] x_scaled, y_scaled, dx, dy;
    logic [31:0]          arc;
    logic signed [32:0]   z_rounded, z_shifted;
    logic signed [AW-1:0] angle, ref_ext, base, d_hi, d_lo, fixed;
    logic [AW-1:0]        mask;

    assign x_scaled = {{(VW - 32){x_component[15]}}, x_component, 16'b0};
    assign y_scaled = {{(VW - 32){y_component[15]}}, y_component, 16'b0};
    assign dx  = y_reg >>> cmd.step;
    assign dy  = x_reg >>> cmd.step;
    assign arc = catu_pkg::ARC_TABLE[cmd.step];

    // round the signed turn accumulator to the output fraction
    assign z_rounded = $signed({z_reg[31], z_reg}) + ROUND_HALF;
    assign z_shifted = z_rounded >>> (32 - FRACTION_BITS);
    assign angle     = zero_reg ? '0 : AW'(z_shifted);

    assign mask    = half_turn_period ? MASK_HALF : MASK_FULL;
    assign ref_ext = AW'(ref_reg);
    assign base    = ref_ext & ~mask;

    // whole periods needed to bring temp back inside the window
    assign d_hi  = temp_reg - hi_reg;
    assign d_lo  = lo_reg - temp_reg;
    assign fixed = (temp_reg < lo_reg) ? temp_reg + ((d_lo + mask) & ~mask) : temp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            zero_reg <= (x_component == 16'sd0) && (y_component == 16'sd0);
            ref_reg  <= restart ? seed_angle : reference_reg;
            if (x_component[15]) begin
                x_reg <= -x_scaled;
                y_reg <= -y_scaled;
                z_reg <= 32'h8000_0000;
            end else begin
                x_reg <= x_scaled;
                y_reg <= y_scaled;
                z_reg <= '0;
            end
        end else if (cmd.rotate) begin
            if (!y_reg[VW-1]) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + arc;
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - arc;
            end
        end
        if (cmd.sum) begin
            temp_reg <= angle + base;
            hi_reg   <= ref_ext + EIGHTH;
            lo_reg   <= ref_ext - EIGHTH;
        end else if (cmd.fix_hi) begin
            if (temp_reg > hi_reg) begin
                temp_reg <= temp_reg - ((d_hi + mask) & ~mask);
            end
        end
        if (cmd.commit) begin
            out_data_reg <= fixed[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reference_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                reference_reg <= fixed[31:0];
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign unwrapped_angle = out_data_reg;

endmodule

// File: rtl/core/continuous_atan2_unwrap.sv
// top level: continuous multi-turn atan2 with apb mode register
//
//  channel   | ports                      | contents
//  ----------+----------------------------+------------------------------------------
//  input     | s_tvalid s_tready s_tdata  | y, x, seed angle; s_tuser = restart
//  result    | m_tvalid m_tready m_tdata  | unwrapped angle, 16 fraction bits
//  config    | psel penable pwrite paddr  | half_turn_period at byte address 0
//
//  an item is loaded, then the shared cordic step unit runs once per cycle for each
//  of the CORDIC_STEPS steps (capped at the table depth), then sum, upper fix and lower fix
//  synchronous active-low reset clears the mode, the reference angle and output valid
//  a new request is taken while the previous result still waits in the output
//  register; the lower-fix cycle holds while that register is occupied and not being taken
module continuous_atan2_unwrap #(
    parameter int CORDIC_STEPS  = catu_pkg::CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = catu_pkg::FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,  // y_component, x_component, seed_angle
    input  logic                            s_tuser,  // restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // unwrapped_angle
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [catu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [catu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [catu_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam logic [catu_pkg::APB_ADDR_W-3:0] IDX_HALF_TURN =
        (catu_pkg::APB_ADDR_W - 2)'(catu_pkg::REG_HALF_TURN);

    logic                   half_turn_period_reg;
    logic                   cfg_write;
    catu_pkg::catu_cmd_t    cmd;
    catu_pkg::catu_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_turn_period_reg <= 1'b0;
        end else if (cfg_write && (paddr[catu_pkg::APB_ADDR_W-1:2] == IDX_HALF_TURN)) begin
            half_turn_period_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[catu_pkg::APB_ADDR_W-1:2] == IDX_HALF_TURN) begin
            prdata[0] = half_turn_period_reg;
        end
    end

    catu_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    catu_datapath #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .half_turn_period(half_turn_period_reg),
        .y_component     (s_tdata[15:0]),
        .x_component     (s_tdata[31:16]),
        .restart         (s_tuser),
        .seed_angle      (s_tdata[63:32]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .unwrapped_angle (m_tdata)
    );

endmodule

// File: rtl/core/catu_checker.sv
// port-level checks for the atan2 unwrap block, bound to the top level
module catu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        psel,
    input logic        pready
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: no new request is accepted right after one is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken while a request is in work");

    // no result can appear right after a request while the output was empty
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("apb wait state inserted");

endmodule

bind continuous_atan2_unwrap catu_checker u_catu_checker (.*);
